// ----- rtl/pcs_pkg.sv -----
// ----------------------------------------------------------------------------
// pcs_pkg: shared types, constants and helpers for the pid step unit
// fixed-point widths, register map, config bundle and saturation functions
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int OP_W       = DATA_WIDTH + 1;   // widest multiplier operand
  localparam int PROD_W     = 2 * OP_W;         // product magnitude
  localparam int MAG_W      = PROD_W + 1;
  localparam int NUM_W      = 52;               // dividend magnitude
  localparam int DEN_W      = 20;               // divisor, holds one million
  localparam int DT_W       = 19;               // elapsed time, at most 500000
  localparam int CNT_W      = 6;
  localparam int SUM_W      = DATA_WIDTH + 2;
  localparam int LIM_W      = 31;
  localparam int ADDR_W     = 5;

  localparam logic [DEN_W-1:0]      US_PER_SEC    = DEN_W'(1000000);
  localparam logic [DATA_WIDTH-1:0] MAX_DT_US     = DATA_WIDTH'(500000);
  localparam logic [DT_W-1:0]       DEFAULT_DT_US = DT_W'(1000);

  // register map, index = byte address / 4
  typedef enum logic [2:0] {
    REG_P_GAIN  = 3'd0,
    REG_I_GAIN  = 3'd1,
    REG_D_GAIN  = 3'd2,
    REG_OUT_LIM = 3'd3,
    REG_SLEW    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] p_gain;
    logic [DATA_WIDTH-1:0] i_gain;
    logic [DATA_WIDTH-1:0] d_gain;
    logic [LIM_W-1:0]      output_limit;
    logic [LIM_W-1:0]      slew_limit;
  } cfg_t;

  typedef struct packed {
    logic              neg;
    logic [PROD_W-1:0] mag;
  } prod_t;

  localparam logic [DATA_WIDTH-1:0] POS_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] NEG_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // saturate sign + magnitude to a signed data word
  function automatic logic [DATA_WIDTH-1:0] sat_mag(input logic neg,
                                                    input logic [MAG_W-1:0] m);
    logic [DATA_WIDTH-1:0] r;
    if (!neg) begin
      r = (m > MAG_W'(POS_MAX)) ? POS_MAX : m[DATA_WIDTH-1:0];
    end else begin
      r = (m > MAG_W'(NEG_MIN)) ? NEG_MIN : (~m[DATA_WIDTH-1:0] + 1'b1);
    end
    return r;
  endfunction

  // floor of a signed product over 2^FRAC_BITS (or 2^(FRAC_BITS+1)), saturated
  function automatic logic [DATA_WIDTH-1:0] fshift_sat(input prod_t p,
                                                       input logic extra);
    logic [PROD_W-1:0] q;
    logic              rb;
    logic [MAG_W-1:0]  m;
    if (extra) begin
      q  = p.mag >> (FRAC_BITS + 1);
      rb = |p.mag[FRAC_BITS:0];
    end else begin
      q  = p.mag >> FRAC_BITS;
      rb = |p.mag[FRAC_BITS-1:0];
    end
    m = {1'b0, q} + MAG_W'(p.neg & rb);
    return sat_mag(p.neg, m);
  endfunction

  function automatic logic [DATA_WIDTH-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
    logic [DATA_WIDTH-1:0] r;
    if (v > $signed(SUM_W'(POS_MAX)))
      r = POS_MAX;
    else if (v < -$signed(SUM_W'(NEG_MIN)))
      r = NEG_MIN;
    else
      r = v[DATA_WIDTH-1:0];
    return r;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] clamp_lim(input logic signed [SUM_W-1:0] v,
                                                      input logic [LIM_W-1:0] lim);
    logic signed [SUM_W-1:0] l;
    logic [DATA_WIDTH-1:0]   r;
    l = $signed(SUM_W'(lim));
    if (v > l)
      r = l[DATA_WIDTH-1:0];
    else if (v < -l)
      r = DATA_WIDTH'(-l);
    else
      r = v[DATA_WIDTH-1:0];
    return r;
  endfunction

endpackage

// ----- rtl/pcs_regs.sv -----
// ----------------------------------------------------------------------------
// pcs_regs: configuration register file
// apb-style write and read of gains, output limit and slew limit
// ----------------------------------------------------------------------------
module pcs_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcs_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output pcs_pkg::cfg_t                 cfg
);

  pcs_pkg::cfg_t cfg_r;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx    = paddr[pcs_pkg::ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.p_gain       <= 32'd13107;
      cfg_r.i_gain       <= 32'd131072;
      cfg_r.d_gain       <= 32'd0;
      cfg_r.output_limit <= 31'd786432;
      cfg_r.slew_limit   <= 31'd65536000;
    end else if (wr_en) begin
      case (idx)
        pcs_pkg::REG_P_GAIN:  cfg_r.p_gain       <= pwdata;
        pcs_pkg::REG_I_GAIN:  cfg_r.i_gain       <= pwdata;
        pcs_pkg::REG_D_GAIN:  cfg_r.d_gain       <= pwdata;
        pcs_pkg::REG_OUT_LIM: cfg_r.output_limit <= pwdata[30:0];
        pcs_pkg::REG_SLEW:    cfg_r.slew_limit   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pcs_pkg::REG_P_GAIN:  prdata = cfg_r.p_gain;
      pcs_pkg::REG_I_GAIN:  prdata = cfg_r.i_gain;
      pcs_pkg::REG_D_GAIN:  prdata = cfg_r.d_gain;
      pcs_pkg::REG_OUT_LIM: prdata = {1'b0, cfg_r.output_limit};
      pcs_pkg::REG_SLEW:    prdata = {1'b0, cfg_r.slew_limit};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/pcs_mul.sv -----
// ----------------------------------------------------------------------------
// pcs_mul: bit-serial signed multiplier
// sign-magnitude shift-add, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module pcs_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pcs_pkg::OP_W-1:0]    a,
  input  logic [pcs_pkg::OP_W-1:0]    b,
  output logic                        done,
  output pcs_pkg::prod_t              prod
);

  localparam int W = pcs_pkg::OP_W;

  logic                       run_r;
  logic                       done_r;
  logic [pcs_pkg::CNT_W-1:0]  cnt_r;
  logic [W-1:0]               amag_r;
  logic [W-1:0]               b_r;
  logic [2*W-1:0]             acc_r;
  logic                       neg_r;
  logic [W:0]                 sum;

  assign sum  = {1'b0, acc_r[2*W-1:W]} + (b_r[0] ? {1'b0, amag_r} : '0);
  assign done = done_r;
  assign prod = '{neg: neg_r, mag: acc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == pcs_pkg::CNT_W'(W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand and accumulator shift path
  always_ff @(posedge clk) begin
    if (start) begin
      amag_r <= a[W-1] ? (~a + 1'b1) : a;
      b_r    <= b[W-1] ? (~b + 1'b1) : b;
      neg_r  <= a[W-1] ^ b[W-1];
      acc_r  <= '0;
    end else if (run_r) begin
      acc_r <= {sum, acc_r[W-1:1]};
      b_r   <= b_r >> 1;
    end
  end

endmodule

// ----- rtl/pcs_div.sv -----
// ----------------------------------------------------------------------------
// pcs_div: bit-serial restoring divider with floor rounding
// one quotient bit per cycle, then a fix-up step that floors the quotient of negative dividends
// ----------------------------------------------------------------------------
module pcs_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          neg,
  input  logic [pcs_pkg::NUM_W-1:0]     num,
  input  logic [pcs_pkg::DEN_W-1:0]     den,
  output logic                          done,
  output logic                          q_neg,
  output logic [pcs_pkg::NUM_W:0]       q_mag
);

  localparam int NW = pcs_pkg::NUM_W;
  localparam int DW = pcs_pkg::DEN_W;

  logic                       run_r;
  logic                       fix_r;
  logic                       done_r;
  logic [pcs_pkg::CNT_W-1:0]  cnt_r;
  logic [NW-1:0]              q_r;
  logic [NW:0]                qf_r;
  logic [DW-1:0]              rem_r;
  logic [DW-1:0]              den_r;
  logic                       neg_r;
  logic [DW:0]                part;
  logic                       ge;
  logic [DW:0]                diff;

  assign part  = {rem_r, q_r[NW-1]};
  assign ge    = part >= {1'b0, den_r};
  assign diff  = part - {1'b0, den_r};
  assign done  = done_r;
  assign q_neg = neg_r;
  assign q_mag = qf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      fix_r  <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == pcs_pkg::CNT_W'(NW - 1)) begin
          run_r <= 1'b0;
          fix_r <= 1'b1;
        end
      end else if (fix_r) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
      neg_r <= neg;
    end else if (run_r) begin
      rem_r <= ge ? diff[DW-1:0] : part[DW-1:0];
      q_r   <= {q_r[NW-2:0], ge};
    end
    // floor for negative dividends with a remainder
    if (fix_r) begin
      qf_r <= {1'b0, q_r} + (NW+1)'(neg_r && (rem_r != '0));
    end
  end

endmodule

// ----- rtl/pid_controller_step_unit.sv -----
// ----------------------------------------------------------------------------
// pid_controller_step_unit: q16.16 pid step with tustin integral and slew limit
// sequencer around a bit-serial multiplier and a bit-serial divider
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in      | input     | in_valid/in_stall  | in_error_in, in_now_us
//  out     | output    | out_valid/out_stall| out_drive
//  cfg     | input     | psel/penable/pready| paddr, pwdata, prdata
//
//  each transaction runs five multiplies and two divides with the slew limit
//  off and six multiplies and three divides with it on, one after another
//  through the shared serial units
//  reset is synchronous and active low; it restores the register defaults
//  and clears the integral, last error, last drive and last timestamp
//  in_stall is high from acceptance until the result is moved into the
//  output register, which holds it while out_stall is high; a new input
//  transaction is taken as soon as that move is done
//
module pid_controller_step_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            in_error_in,
  input  logic [31:0]                   in_now_us,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_drive,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcs_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int DW = pcs_pkg::DATA_WIDTH;
  localparam int OW = pcs_pkg::OP_W;
  localparam int SW = pcs_pkg::SUM_W;

  // one-hot sequencer states
  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_PROP = 11'b000_0000_0010,  // p * e
    S_RATE = 11'b000_0000_0100,  // i * (e + e_prev)
    S_IMUL = 11'b000_0000_1000,  // rate * dt
    S_IDIV = 11'b000_0001_0000,  // / 1e6
    S_DMUL = 11'b000_0010_0000,  // d * (e - e_prev)
    S_DSCL = 11'b000_0100_0000,  // dq * 1e6
    S_DDIV = 11'b000_1000_0000,  // / dt
    S_SMUL = 11'b001_0000_0000,  // slew * dt
    S_SDIV = 11'b010_0000_0000,  // / 1e6
    S_DONE = 11'b100_0000_0000
  } state_t;

  state_t state_r;

  pcs_pkg::cfg_t  cfg;
  pcs_pkg::prod_t mul_prod;
  logic           mul_done;
  logic           div_done;
  logic           div_neg;
  logic [pcs_pkg::NUM_W:0] div_q;

  // shared unit operands, registered in the same cycle as the start pulse
  logic                       mul_go_r;
  logic [OW-1:0]              mul_a_r;
  logic [OW-1:0]              mul_b_r;
  logic                       div_go_r;
  logic                       div_neg_r;
  logic [pcs_pkg::NUM_W-1:0]  div_num_r;
  logic [pcs_pkg::DEN_W-1:0]  div_den_r;

  // controller state
  logic [DW-1:0]  integ_acc_r;
  logic [DW-1:0]  last_err_r;
  logic [DW-1:0]  last_drv_r;
  logic [31:0]    last_time_r;

  // per-transaction working registers
  logic [DW-1:0]              err_r;
  logic [31:0]                now_r;
  logic [pcs_pkg::DT_W-1:0]   dt_r;
  logic [DW-1:0]              prop_r;
  logic [DW-1:0]              integ_r;
  logic [DW-1:0]              drive_r;

  logic                       out_valid_r;
  logic [DW-1:0]              out_drive_r;

  logic                       in_acc;
  logic                       out_load;
  logic [31:0]                dtu;
  logic [pcs_pkg::DT_W-1:0]   dt_sel;
  logic [OW-1:0]              e_sum;
  logic [OW-1:0]              e_dif;
  logic [DW-1:0]              q_sat;
  logic signed [SW-1:0]       integ_sum;
  logic signed [SW-1:0]       drive_sum;
  logic signed [SW-1:0]       delta;
  logic signed [SW-1:0]       step;

  pcs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pcs_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go_r),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  pcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .neg   (div_neg_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .done  (div_done),
    .q_neg (div_neg),
    .q_mag (div_q)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // elapsed time, modulo 2^32, with the fallback for zero or long gaps
  assign dtu    = in_now_us - last_time_r;
  assign dt_sel = (dtu == 32'd0 || dtu > pcs_pkg::MAX_DT_US) ?
                  pcs_pkg::DEFAULT_DT_US : dtu[pcs_pkg::DT_W-1:0];

  assign e_sum = {err_r[DW-1], err_r} + {last_err_r[DW-1], last_err_r};
  assign e_dif = {err_r[DW-1], err_r} - {last_err_r[DW-1], last_err_r};

  assign q_sat = pcs_pkg::sat_mag(div_neg, pcs_pkg::MAG_W'(div_q));

  assign integ_sum = $signed(SW'({{2{integ_acc_r[DW-1]}}, integ_acc_r}))
                   + $signed(SW'({{2{q_sat[DW-1]}}, q_sat}));
  assign drive_sum = $signed({{2{prop_r[DW-1]}}, prop_r})
                   + $signed({{2{integ_r[DW-1]}}, integ_r})
                   + $signed({{2{q_sat[DW-1]}}, q_sat});
  assign delta     = $signed({{2{drive_r[DW-1]}}, drive_r})
                   - $signed({{2{last_drv_r[DW-1]}}, last_drv_r});
  // slew step is below 2^30, so the low bits carry it whole
  assign step      = $signed(SW'(div_q[DW-2:0]));

  // control and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mul_go_r    <= 1'b0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      integ_acc_r <= '0;
      last_err_r  <= '0;
      last_drv_r  <= '0;
      last_time_r <= '0;
    end else begin
      mul_go_r <= 1'b0;
      div_go_r <= 1'b0;
      // a new result may replace one taken in the same cycle
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            mul_go_r <= 1'b1;
            state_r  <= S_PROP;
          end
        end
        S_PROP: begin
          if (mul_done) begin
            mul_go_r <= 1'b1;
            state_r  <= S_RATE;
          end
        end
        S_RATE: begin
          if (mul_done) begin
            mul_go_r <= 1'b1;
            state_r  <= S_IMUL;
          end
        end
        S_IMUL: begin
          if (mul_done) begin
            div_go_r <= 1'b1;
            state_r  <= S_IDIV;
          end
        end
        S_IDIV: begin
          if (div_done) begin
            mul_go_r <= 1'b1;
            state_r  <= S_DMUL;
          end
        end
        S_DMUL: begin
          if (mul_done) begin
            mul_go_r <= 1'b1;
            state_r  <= S_DSCL;
          end
        end
        S_DSCL: begin
          if (mul_done) begin
            div_go_r <= 1'b1;
            state_r  <= S_DDIV;
          end
        end
        S_DDIV: begin
          if (div_done) begin
            if (cfg.slew_limit != '0) begin
              mul_go_r <= 1'b1;
              state_r  <= S_SMUL;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_SMUL: begin
          if (mul_done) begin
            div_go_r <= 1'b1;
            state_r  <= S_SDIV;
          end
        end
        S_SDIV: begin
          if (div_done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            integ_acc_r <= integ_r;
            last_err_r  <= err_r;
            last_drv_r  <= drive_r;
            last_time_r <= now_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_drive_r <= drive_r;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          err_r   <= in_error_in;
          now_r   <= in_now_us;
          dt_r    <= dt_sel;
          mul_a_r <= {cfg.p_gain[DW-1], cfg.p_gain};
          mul_b_r <= {in_error_in[DW-1], in_error_in};
        end
      end
      S_PROP: begin
        if (mul_done) begin
          prop_r  <= pcs_pkg::fshift_sat(mul_prod, 1'b0);
          mul_a_r <= {cfg.i_gain[DW-1], cfg.i_gain};
          mul_b_r <= e_sum;
        end
      end
      S_RATE: begin
        // halving of the tustin sum folds into one more shift bit
        if (mul_done) begin
          mul_a_r <= OW'($signed(pcs_pkg::fshift_sat(mul_prod, 1'b1)));
          mul_b_r <= OW'(dt_r);
        end
      end
      S_IMUL: begin
        if (mul_done) begin
          div_neg_r <= mul_prod.neg;
          div_num_r <= mul_prod.mag[pcs_pkg::NUM_W-1:0];
          div_den_r <= pcs_pkg::US_PER_SEC;
        end
      end
      S_IDIV: begin
        if (div_done) begin
          integ_r <= pcs_pkg::clamp_lim(integ_sum, cfg.output_limit);
          mul_a_r <= {cfg.d_gain[DW-1], cfg.d_gain};
          mul_b_r <= e_dif;
        end
      end
      S_DMUL: begin
        if (mul_done) begin
          mul_a_r <= OW'($signed(pcs_pkg::fshift_sat(mul_prod, 1'b0)));
          mul_b_r <= OW'(pcs_pkg::US_PER_SEC);
        end
      end
      S_DSCL: begin
        if (mul_done) begin
          div_neg_r <= mul_prod.neg;
          div_num_r <= mul_prod.mag[pcs_pkg::NUM_W-1:0];
          div_den_r <= pcs_pkg::DEN_W'(dt_r);
        end
      end
      S_DDIV: begin
        if (div_done) begin
          drive_r <= pcs_pkg::clamp_lim(
                       $signed(SW'($signed(pcs_pkg::sat_sum(drive_sum)))),
                       cfg.output_limit);
          mul_a_r <= OW'(cfg.slew_limit);
          mul_b_r <= OW'(dt_r);
        end
      end
      S_SMUL: begin
        if (mul_done) begin
          div_neg_r <= 1'b0;
          div_num_r <= mul_prod.mag[pcs_pkg::NUM_W-1:0];
          div_den_r <= pcs_pkg::US_PER_SEC;
        end
      end
      S_SDIV: begin
        // delta beyond the allowed step moves the drive by one step, saturated to the data word
        if (div_done) begin
          if (delta > step) begin
            drive_r <= pcs_pkg::sat_sum(
                         $signed({{2{last_drv_r[DW-1]}}, last_drv_r}) + step);
          end else if (-delta > step) begin
            drive_r <= pcs_pkg::sat_sum(
                         $signed({{2{last_drv_r[DW-1]}}, last_drv_r}) - step);
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- tb/sv/tb_pid_controller_step_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pid_controller_step_unit: self-checking bench for the pid step unit
// drives error/timestamp transactions with random idling and stalls, predicts
// each drive value with a bit-exact fixed-point pid model and checks every
// output transaction in order; gains, limits and slew are swept between phases
// ----------------------------------------------------------------------------
module tb_pid_controller_step_unit;

  localparam int  N_RANDOM   = 1400;
  localparam int  SETTLE_CYC = 500;
  localparam longint USEC    = 1000000;

  typedef struct packed {
    logic [31:0] err;
    logic [31:0] stamp;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_error_in = '0;
  logic [31:0] in_now_us = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_drive;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [pcs_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pid_controller_step_unit dut (.*);

  always #4 clk = ~clk;

  // predictor copy of registers and loop state
  longint kp, ki, kd, lim, slew;
  longint acc, prev_err, prev_drive;
  logic [31:0] prev_stamp;

  sample_t pending_q[$];
  logic [31:0] drive_q[$];
  int errors = 0;
  logic quiet = 1'b0;      // sender holds until results drain
  logic no_idle = 1'b0;    // stretch without idling
  logic hold_go = 1'b0;    // request for the receiver long hold-off
  logic hold_used = 1'b0;
  int hold_cycles = 0;     // receiver long hold-off
  int accepted = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clip(longint v, longint l);
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

  function automatic longint fdiv(longint v, longint d);
    longint q;
    q = v / d;
    if ((v % d) != 0 && v < 0) q -= 1;
    return q;
  endfunction

  // next drive value for one error sample; updates the loop state
  function automatic logic [31:0] pid_next_drive(sample_t s);
    longint e, dt, p1, p2, half, rate, iterm, integ, prop, dq, deriv, drv, bound, stp;
    logic [31:0] gap;
    e = longint'($signed(s.err));
    gap = s.stamp - prev_stamp;
    if (gap == 0 || gap > 32'd500000) gap = 32'd1000;
    dt = longint'(gap);
    prop = sat32((kp * e) >>> pcs_pkg::FRAC_BITS);
    p1 = ki * e;
    p2 = ki * prev_err;
    half = (p1 >>> 1) + (p2 >>> 1) + (p1 & p2 & 1);
    rate = sat32(half >>> pcs_pkg::FRAC_BITS);
    iterm = sat32(fdiv(rate * dt, USEC));
    integ = clip(acc + iterm, lim);
    dq = sat32((kd * (e - prev_err)) >>> pcs_pkg::FRAC_BITS);
    deriv = sat32(fdiv(dq * USEC, dt));
    drv = clip(sat32(prop + integ + deriv), lim);
    if (slew > 0) begin
      bound = slew * dt;
      stp = fdiv(bound, USEC);
      if ((drv - prev_drive) * USEC > bound) drv = sat32(prev_drive + stp);
      else if ((drv - prev_drive) * USEC < -bound) drv = sat32(prev_drive - stp);
    end
    acc = integ;
    prev_drive = drv;
    prev_err = e;
    prev_stamp = s.stamp;
    return drv[31:0];
  endfunction

  // driver: offers pending transactions, idles at random
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        drive_q.push_back(pid_next_drive({in_error_in, in_now_us}));
        accepted <= accepted + 1;
      end
      if (!(in_valid && in_stall)) begin
        if (pending_q.size() > 0 && !quiet && (no_idle || $urandom_range(99) >= 25)) begin
          in_valid <= 1'b1;
          in_error_in <= pending_q[0].err;
          in_now_us <= pending_q[0].stamp;
          void'(pending_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random stall on the result side, compare against predictions
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (drive_q.size() == 0) begin
          $display("%0t: unexpected drive %h", $time, out_drive);
          errors++;
        end else begin
          if (out_drive !== drive_q[0]) begin
            $display("%0t: drive mismatch expected %h actual %h", $time, drive_q[0],
                     out_drive);
            errors++;
          end
          void'(drive_q.pop_front());
        end
      end
      if (hold_go && !hold_used) begin
        hold_used <= 1'b1;
        hold_cycles <= 3000;
        out_stall <= 1'b1;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(99) < 25);
      end
    end
  end

  task automatic cfg_write(pcs_pkg::reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= pcs_pkg::ADDR_W'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      pcs_pkg::REG_P_GAIN:  kp = longint'($signed(val));
      pcs_pkg::REG_I_GAIN:  ki = longint'($signed(val));
      pcs_pkg::REG_D_GAIN:  kd = longint'($signed(val));
      pcs_pkg::REG_OUT_LIM: lim = longint'(val[30:0]);
      pcs_pkg::REG_SLEW:    slew = longint'(val[30:0]);
      default: ;
    endcase
  endtask

  // wait until every queued transaction has been sent and answered
  task automatic drain();
    while (pending_q.size() > 0 || in_valid || drive_q.size() > 0) @(negedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  logic [31:0] clock_us;

  task automatic push(logic [31:0] err, logic [31:0] stamp);
    sample_t s;
    s.err = err;
    s.stamp = stamp;
    pending_q.push_back(s);
  endtask

  // mostly small steps in time, sometimes repeats, long gaps and wraps
  task automatic push_random(int n);
    logic [31:0] e;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 70) clock_us += $urandom_range(2000, 1);
      else if (k < 78) clock_us += 0;
      else if (k < 85) clock_us += $urandom_range(32'd600000, 32'd500001);
      else if (k < 90) clock_us += 32'd500000;
      else clock_us = $urandom;
      k = $urandom_range(99);
      if (k < 60) e = 32'($signed($urandom_range(2 * 65536 * 8)) - 65536 * 8);
      else if (k < 80) e = $urandom;
      else if (k < 90) e = 32'h7fff_ffff;
      else e = 32'h8000_0000;
      push(e, clock_us);
    end
  endtask

  task automatic random_cfg();
    int k;
    k = $urandom_range(3);
    cfg_write(pcs_pkg::REG_P_GAIN, k == 0 ? $urandom : $urandom_range(200000));
    cfg_write(pcs_pkg::REG_I_GAIN,
              k == 0 ? $urandom : 32'($signed($urandom_range(400000)) - 200000));
    cfg_write(pcs_pkg::REG_D_GAIN, k == 0 ? $urandom : $urandom_range(300));
    cfg_write(pcs_pkg::REG_OUT_LIM, k == 1 ? 32'h7fff_ffff : $urandom_range(32'd5000000));
    cfg_write(pcs_pkg::REG_SLEW,
              k == 2 ? 32'd0 : (k == 3 ? 32'h7fff_ffff : $urandom_range(32'd90000000)));
  endtask

  initial begin
    kp = 13107; ki = 131072; kd = 0; lim = 786432; slew = 65536000;
    acc = 0; prev_err = 0; prev_drive = 0; prev_stamp = '0;
    clock_us = 32'd100;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset gains, then corners of error and time
    push(32'h0001_0000, 32'd0);          // unchanged timestamp
    push(32'h7fff_ffff, 32'd1000);
    push(32'h8000_0000, 32'd1500);
    push(32'hffff_ffff, 32'd700000);     // gap too long
    push(32'h0000_0000, 32'hffff_fff0);  // just before wrap
    push(32'h0002_0000, 32'h0000_0100);  // across wrap
    push(32'h0002_0000, 32'h0000_0100);
    push(32'hfff0_0000, 32'd500356);     // just beyond the maximum gap
    drain();

    // extreme gains, limit at max, slew off: exercises saturation
    cfg_write(pcs_pkg::REG_P_GAIN, 32'h7fff_ffff);
    cfg_write(pcs_pkg::REG_I_GAIN, 32'h8000_0000);
    cfg_write(pcs_pkg::REG_D_GAIN, 32'h7fff_ffff);
    cfg_write(pcs_pkg::REG_OUT_LIM, 32'h7fff_ffff);
    cfg_write(pcs_pkg::REG_SLEW, 32'd0);
    push(32'h7fff_ffff, 32'd10);
    push(32'h8000_0000, 32'd11);
    push(32'h7fff_ffff, 32'd11);
    push(32'h0000_0001, 32'd400000);
    push(32'hffff_ffff, 32'd400001);
    drain();

    // limit shrunk under a large integral, then zero limit with max slew, then max limit with minimal slew
    cfg_write(pcs_pkg::REG_OUT_LIM, 32'd65536);
    push(32'h0010_0000, 32'd401000);
    push(32'hfff0_0000, 32'd402000);
    drain();
    cfg_write(pcs_pkg::REG_OUT_LIM, 32'd0);
    cfg_write(pcs_pkg::REG_SLEW, 32'h7fff_ffff);
    push(32'h0100_0000, 32'd403000);
    push(32'h8000_0000, 32'd403001);
    drain();
    cfg_write(pcs_pkg::REG_OUT_LIM, 32'h7fff_ffff);
    cfg_write(pcs_pkg::REG_SLEW, 32'd1);
    push(32'h7fff_ffff, 32'd404000);
    push(32'h8000_0000, 32'd900000);
    drain();

    // random phases with new settings between them
    for (int ph = 0; ph < 7; ph++) begin
      random_cfg();
      if (ph == 2) no_idle = 1'b1;
      if (ph == 3) no_idle = 1'b0;
      push_random(N_RANDOM / 7);
      if (ph == 4) begin
        // receiver holds off while the sender keeps offering
        while (accepted < 3) @(posedge clk);
        hold_go = 1'b1;
      end
      if (ph == 5) begin
        // sender pauses until every result has come back
        while (pending_q.size() > 100) @(posedge clk);
        quiet = 1'b1;
        while (in_valid || drive_q.size() > 0) @(negedge clk);
        quiet = 1'b0;
      end
      drain();
    end

    if (errors == 0 && drive_q.size() == 0 && pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // overall limit, several times the slowest run
  initial begin
    #(64'd8 * 64'd6000000);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pcs_pkg.sv
rtl/pcs_regs.sv
rtl/pcs_mul.sv
rtl/pcs_div.sv
rtl/pid_controller_step_unit.sv
tb/sv/tb_pid_controller_step_unit.sv
